@@ sv/mtws_pkg.sv @@
// Package for the multi-task watchdog supervisor.
// Holds slot sizing, register indexes, item mode codes and the time-store request type.
// No dependencies.
package mtws_pkg;

	localparam int TASK_SLOTS = 8;
	localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
	localparam int TIME_W     = 32;
	localparam int NUM_PAIRS  = 4;
	localparam int NUM_IVL    = 2 * NUM_PAIRS;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int TCOUNT_W   = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IVL_PAIR_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IVL_PAIR_3 = 3'd4;

	// Input item modes
	localparam logic MODE_CHECKIN = 1'b0;
	localparam logic MODE_UPDATE  = 1'b1;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [TIME_W-1:0] time_t;

	// Request from the sequencer to the check-in time store
	typedef struct packed {
		logic  wr_en;
		slot_t wr_addr;
		time_t wr_data;
		logic  rd_en;
		slot_t rd_addr;
	} mem_req_t;

endpackage

@@ sv/mtws_time_mem.sv @@
// Check-in time store: one synchronous memory of TASK_SLOTS entries, registered read.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on mtws_pkg.
module mtws_time_mem import mtws_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output time_t    rd_data
);

	time_t                 mem [TASK_SLOTS];
	logic [TASK_SLOTS-1:0] vld_q;
	time_t                 data_s1;
	logic                  vld_s1;

	// Write and read the array
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			data_s1 <= mem[req.rd_addr];
		end
	end

	// Track written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				vld_s1 <= vld_q[req.rd_addr];
			end
		end
	end

	// Mask entries never written since reset
	assign rd_data = vld_s1 ? data_s1 : '0;

endmodule

@@ sv/multi_task_watchdog_supervisor.sv @@
// Multi-task watchdog supervisor: task check-ins and periodic overdue scans.
// A check-in request gives no result; the next request may follow at once.
// An update scans the n active slots one per cycle, then registers its result from the done
// state (straight from acceptance when n is 0); the next request is taken once it is loaded.
// Reset: all intervals and the task count zero, all tasks healthy, check-in times zero.
// Depends on mtws_pkg and mtws_time_mem.
module multi_task_watchdog_supervisor import mtws_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  mode,
	input  logic [2:0]            task_id,
	input  logic [31:0]           time_ms,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  feed,
	output logic [2:0]            fail_slot,
	output logic [7:0]            unhealthy_mask,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]            state_q;
	logic [TCOUNT_W-1:0]   task_count_q;
	time_t                 ivl_q [NUM_IVL];
	logic [TASK_SLOTS-1:0] healthy_q;
	slot_t                 last_failed_q;
	time_t                 update_time_q;
	logic                  fail_q;
	slot_t                 rd_idx_q;
	logic                  issue_q;
	logic                  cmp_vld_s1;
	logic                  cmp_last_s1;
	slot_t                 idx_s1;
	logic                  out_valid_q;
	logic                  feed_q;
	logic [2:0]            failed_q;
	logic [7:0]            mask_q;

	logic [CNT_W-1:0]      n_eff;
	slot_t                 n_last;
	logic                  in_acc;
	logic                  do_checkin;
	logic                  start_update;
	logic                  overdue;
	logic                  out_load;
	logic [7:0]            mask_now;
	time_t                 ckt;
	time_t                 elapsed;
	mem_req_t              mreq;
	logic [CFG_IDX_W-1:0]  pair_idx;

	// Clamp the task count to the slot count
	always_comb begin
		if (task_count_q > TCOUNT_W'(TASK_SLOTS)) begin
			n_eff = CNT_W'(TASK_SLOTS);
		end else begin
			n_eff = CNT_W'(task_count_q);
		end
	end
	assign n_last = SLOT_W'(n_eff - CNT_W'(1));

	assign cfg_ready    = 1'b1;
	assign in_stall     = (state_q != ST_IDLE);
	assign in_acc       = in_valid && !in_stall;
	assign do_checkin   = in_acc && (mode == MODE_CHECKIN)
		&& ({{(CNT_W > 3 ? CNT_W - 3 : 0){1'b0}}, task_id} < n_eff);
	assign start_update = in_acc && (mode == MODE_UPDATE);

	// Drive the time store: check-ins write, the scan reads
	always_comb begin
		mreq.wr_en   = do_checkin;
		mreq.wr_addr = SLOT_W'(task_id);
		mreq.wr_data = update_time_q;
		mreq.rd_en   = (state_q == ST_SCAN) && issue_q;
		mreq.rd_addr = rd_idx_q;
	end

	mtws_time_mem u_time_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.rd_data (ckt)
	);

	// Compare the wrapping elapsed time against the slot interval
	assign elapsed = update_time_q - ckt;
	assign overdue = cmp_vld_s1 && (elapsed > ivl_q[idx_s1]);

	// Build the unhealthy mask from the flags
	always_comb begin
		mask_now = '0;
		for (int i = 0; i < TASK_SLOTS && i < 8; i++) begin
			mask_now[i] = ~healthy_q[i];
		end
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// Write configuration registers
	assign pair_idx = cfg_index - CFG_IVL_PAIR_0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
			for (int i = 0; i < NUM_IVL; i++) begin
				ivl_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index) inside
				CFG_TASK_COUNT: begin
					task_count_q <= cfg_data[TCOUNT_W-1:0];
				end
				[CFG_IVL_PAIR_0:CFG_IVL_PAIR_3]: begin
					for (int p = 0; p < NUM_PAIRS; p++) begin
						if (pair_idx == CFG_IDX_W'(p)) begin
							ivl_q[2*p]     <= cfg_data[TIME_W-1:0];
							ivl_q[2*p + 1] <= cfg_data[2*TIME_W-1:TIME_W];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Sequence check-ins, scans and result hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			healthy_q     <= '1;
			last_failed_q <= '0;
			update_time_q <= '0;
			fail_q        <= 1'b0;
			rd_idx_q      <= '0;
			issue_q       <= 1'b0;
			cmp_vld_s1    <= 1'b0;
			cmp_last_s1   <= 1'b0;
			idx_s1        <= '0;
		end else begin
			cmp_vld_s1  <= 1'b0;
			cmp_last_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (do_checkin) begin
						healthy_q[SLOT_W'(task_id)] <= 1'b1;
					end
					if (start_update) begin
						update_time_q <= time_ms;
						fail_q        <= 1'b0;
						rd_idx_q      <= '0;
						if (n_eff == '0) begin
							state_q <= ST_DONE;
						end else begin
							issue_q <= 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// advance the read pointer
					if (issue_q) begin
						cmp_vld_s1  <= 1'b1;
						idx_s1      <= rd_idx_q;
						cmp_last_s1 <= (rd_idx_q == n_last);
						if (rd_idx_q == n_last) begin
							issue_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + SLOT_W'(1);
						end
					end
					// mark overdue slots; later slots overwrite the failed index
					if (overdue) begin
						healthy_q[idx_s1] <= 1'b0;
						fail_q            <= 1'b1;
						last_failed_q     <= idx_s1;
					end
					if (cmp_last_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			feed_q   <= ~fail_q;
			failed_q <= 3'(last_failed_q);
			mask_q   <= mask_now;
		end
	end

	assign out_valid      = out_valid_q;
	assign feed           = feed_q;
	assign fail_slot      = failed_q;
	assign unhealthy_mask = mask_q;

	// The scan compare only runs inside a scan
	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> (state_q == ST_SCAN))
		else $error("compare outside of scan");

	// The scan never touches an inactive slot
	a_cmp_active: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> ({{(CNT_W - SLOT_W){1'b0}}, idx_s1} < n_eff))
		else $error("scan reached an inactive slot");

	// A new result only comes out of the done state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result without a finished scan");

	// An update with no active tasks finishes at once
	a_empty_update: assert property (@(posedge clk) disable iff (!arst_n)
		(start_update && (n_eff == '0)) |=> (state_q == ST_DONE))
		else $error("empty update did not finish");

endmodule
